### sv/tbba_pkg.sv
// Shared types and constants for the transformed box bound accumulator.
`default_nettype none

package tbba_pkg;

  // Fixed-point word and matrix geometry.
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned AXES          = 3;
  localparam int unsigned COLS          = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef logic signed [WORD_W-1:0] word_t;

  // Saturation limits, which are also the empty-box bounds.
  localparam word_t WORD_MAX = word_t'(32'h7FFF_FFFF);
  localparam word_t WORD_MIN = word_t'(32'h8000_0000);

  // Operation codes carried by a request beat.
  typedef enum logic [1:0] {
    OP_ROW_X  = 2'd0,
    OP_ROW_Y  = 2'd1,
    OP_ROW_Z  = 2'd2,
    OP_EXPAND = 2'd3
  } op_e;

endpackage : tbba_pkg

`default_nettype wire

### sv/tbba_if.sv
// Request and response channel interfaces of the box bound accumulator.
`default_nettype none

interface tbba_req_if import tbba_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  [1:0] operation;
  logic  restart;
  word_t coef_x;
  word_t coef_y;
  word_t coef_z;
  word_t coef_offset;
  word_t local_min_x;
  word_t local_min_y;
  word_t local_min_z;
  word_t local_max_x;
  word_t local_max_y;
  word_t local_max_z;

  modport source (
    output valid, operation, restart, coef_x, coef_y, coef_z, coef_offset,
           local_min_x, local_min_y, local_min_z, local_max_x, local_max_y, local_max_z,
    input  ready
  );
  modport sink (
    input  valid, operation, restart, coef_x, coef_y, coef_z, coef_offset,
           local_min_x, local_min_y, local_min_z, local_max_x, local_max_y, local_max_z,
    output ready
  );
endinterface : tbba_req_if

interface tbba_rsp_if import tbba_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t world_min_x;
  word_t world_min_y;
  word_t world_min_z;
  word_t world_max_x;
  word_t world_max_y;
  word_t world_max_z;

  modport source (
    output valid, world_min_x, world_min_y, world_min_z,
           world_max_x, world_max_y, world_max_z,
    input  ready
  );
  modport sink (
    input  valid, world_min_x, world_min_y, world_min_z,
           world_max_x, world_max_y, world_max_z,
    output ready
  );
endinterface : tbba_rsp_if

`default_nettype wire

### sv/transformed_box_bound_accumulator.sv
// Top level of the transformed box bound accumulator.
//
// Usage: request beats on req_i either load one row of the 3x4 affine matrix
// (operations row x, row y, row z) or expand the running world box with a
// local box (operation expand, optionally restarting from the empty box).
// Only an expand produces a response beat on rsp_o, carrying the updated
// world box. Load all three rows before the first expand.
// An expand beat passes the input register, then the product register, then
// the box register, where its response is valid. Throughput is one beat per
// cycle while rsp_o.ready holds; the limit is the min/max update of the box.
// The box register doubles as the response register. While a response waits,
// up to two more expands (one in the product register, one in the input
// register) and any loads ahead of the second are taken; then req_i.ready
// drops until rsp_o.ready returns.
// Reset empties the pipeline and sets the box to the empty box (min at the
// most positive value, max at the most negative). The matrix is not reset.
`default_nettype none

module transformed_box_bound_accumulator import tbba_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbba_req_if.sink    req_i,
  tbba_rsp_if.source  rsp_o
);

  localparam int unsigned TW = 2 * WORD_W - FRAC_BITS;

  // Input register.
  logic       s1_v_q;
  logic [1:0] s1_op_q;
  logic       s1_restart_q;
  word_t      s1_lo_q   [AXES];
  word_t      s1_hi_q   [AXES];
  word_t      s1_coef_q [COLS];

  // Product register control.
  logic s2_v_q;
  logic s2_restart_q;

  // Box register, also the response register.
  logic  rsp_v_q;
  word_t bound_lo_q [AXES];
  word_t bound_hi_q [AXES];

  word_t mat_q [AXES][COLS];

  logic signed [TW-1:0] tlo [AXES][AXES];
  logic signed [TW-1:0] thi [AXES][AXES];
  word_t                off [AXES];
  word_t                new_lo [AXES];
  word_t                new_hi [AXES];

  logic accept, s1_expand, s1_go, s2_ready, s2_go, out_free;

  // Handshake chain from the response side back to the request side.
  assign out_free    = !rsp_v_q || rsp_o.ready;
  assign s2_go       = s2_v_q && out_free;
  assign s2_ready    = !s2_v_q || out_free;
  assign s1_expand   = (s1_op_q == OP_EXPAND);
  assign s1_go       = s1_v_q && (!s1_expand || s2_ready);
  assign req_i.ready = !s1_v_q || s1_go;
  assign accept      = req_i.valid && req_i.ready;

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_go) begin
      s1_v_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q      <= req_i.operation;
      s1_restart_q <= req_i.restart;
      s1_coef_q[0] <= req_i.coef_x;
      s1_coef_q[1] <= req_i.coef_y;
      s1_coef_q[2] <= req_i.coef_z;
      s1_coef_q[3] <= req_i.coef_offset;
      s1_lo_q[0]   <= req_i.local_min_x;
      s1_lo_q[1]   <= req_i.local_min_y;
      s1_lo_q[2]   <= req_i.local_min_z;
      s1_hi_q[0]   <= req_i.local_max_x;
      s1_hi_q[1]   <= req_i.local_max_y;
      s1_hi_q[2]   <= req_i.local_max_z;
    end
  end

  // Matrix row write when a load leaves the input register.
  always_ff @(posedge clk_i) begin
    if (s1_go && !s1_expand) begin
      for (int c = 0; c < COLS; c++) begin
        mat_q[s1_op_q][c] <= s1_coef_q[c];
      end
    end
  end

  tbba_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (s1_go && s1_expand),
    .mat_i (mat_q),
    .lo_i  (s1_lo_q),
    .hi_i  (s1_hi_q),
    .tlo_o (tlo),
    .thi_o (thi),
    .off_o (off)
  );

  // Product register valid and restart flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s1_go && s1_expand) begin
      s2_v_q <= 1'b1;
    end else if (s2_go) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_expand) begin
      s2_restart_q <= s1_restart_q;
    end
  end

  tbba_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .tlo_i      (tlo),
    .thi_i      (thi),
    .off_i      (off),
    .restart_i  (s2_restart_q),
    .bound_lo_i (bound_lo_q),
    .bound_hi_i (bound_hi_q),
    .new_lo_o   (new_lo),
    .new_hi_o   (new_hi)
  );

  // Running box and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_v_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        bound_lo_q[a] <= WORD_MAX;
        bound_hi_q[a] <= WORD_MIN;
      end
    end else if (s2_go) begin
      rsp_v_q    <= 1'b1;
      bound_lo_q <= new_lo;
      bound_hi_q <= new_hi;
    end else if (rsp_o.ready) begin
      rsp_v_q <= 1'b0;
    end
  end

  assign rsp_o.valid       = rsp_v_q;
  assign rsp_o.world_min_x = bound_lo_q[0];
  assign rsp_o.world_min_y = bound_lo_q[1];
  assign rsp_o.world_min_z = bound_lo_q[2];
  assign rsp_o.world_max_x = bound_hi_q[0];
  assign rsp_o.world_max_y = bound_hi_q[1];
  assign rsp_o.world_max_z = bound_hi_q[2];

endmodule : transformed_box_bound_accumulator

`default_nettype wire

### sv/tbba_mul.sv
// Product stage: all matrix-by-corner-coordinate products, scaled and registered.
`default_nettype none

module tbba_mul import tbba_pkg::*; #(
  parameter  int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned TW        = 2 * WORD_W - FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  word_t                mat_i  [AXES][COLS],
  input  word_t                lo_i   [AXES],
  input  word_t                hi_i   [AXES],
  output logic signed [TW-1:0] tlo_o  [AXES][AXES],
  output logic signed [TW-1:0] thi_o  [AXES][AXES],
  output word_t                off_o  [AXES]
);

  localparam int unsigned PW = 2 * WORD_W;

  logic signed [PW-1:0] plo [AXES][AXES];
  logic signed [PW-1:0] phi [AXES][AXES];
  logic signed [TW-1:0] tlo_q [AXES][AXES];
  logic signed [TW-1:0] thi_q [AXES][AXES];
  word_t                off_q [AXES];

  // Exact products of each coefficient with both ends of its coordinate range.
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int c = 0; c < AXES; c++) begin
        plo[r][c] = PW'(mat_i[r][c]) * PW'(lo_i[c]);
        phi[r][c] = PW'(mat_i[r][c]) * PW'(hi_i[c]);
      end
    end
  end

  // Drop the fraction (floor) and register the terms and row offsets.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          tlo_q[r][c] <= TW'(plo[r][c] >>> FRAC_BITS);
          thi_q[r][c] <= TW'(phi[r][c] >>> FRAC_BITS);
        end
        off_q[r] <= mat_i[r][COLS-1];
      end
    end
  end

  assign tlo_o = tlo_q;
  assign thi_o = thi_q;
  assign off_o = off_q;

endmodule : tbba_mul

`default_nettype wire

### sv/tbba_merge.sv
// Bound merge: extreme row sums over the eight corners, saturated and merged into the box.
`default_nettype none

module tbba_merge import tbba_pkg::*; #(
  parameter  int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned TW        = 2 * WORD_W - FRAC_BITS
) (
  input  logic signed [TW-1:0] tlo_i     [AXES][AXES],
  input  logic signed [TW-1:0] thi_i     [AXES][AXES],
  input  word_t                off_i     [AXES],
  input  logic                 restart_i,
  input  word_t                bound_lo_i [AXES],
  input  word_t                bound_hi_i [AXES],
  output word_t                new_lo_o   [AXES],
  output word_t                new_hi_o   [AXES]
);

  localparam int unsigned SW = TW + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'(WORD_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(WORD_MIN);

  logic signed [SW-1:0] sum_min [AXES];
  logic signed [SW-1:0] sum_max [AXES];
  word_t                w_min   [AXES];
  word_t                w_max   [AXES];
  word_t                base_lo [AXES];
  word_t                base_hi [AXES];

  // Each row sum splits per coordinate, so its corner extremes are the sums
  // of the per-coordinate extremes; saturation keeps that order.
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      sum_min[r] = SW'(off_i[r]);
      sum_max[r] = SW'(off_i[r]);
      for (int c = 0; c < AXES; c++) begin
        if (tlo_i[r][c] < thi_i[r][c]) begin
          sum_min[r] = sum_min[r] + SW'(tlo_i[r][c]);
          sum_max[r] = sum_max[r] + SW'(thi_i[r][c]);
        end else begin
          sum_min[r] = sum_min[r] + SW'(thi_i[r][c]);
          sum_max[r] = sum_max[r] + SW'(tlo_i[r][c]);
        end
      end
    end
  end

  // Saturate to the word range and grow the running box.
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      if (sum_min[r] > SAT_HI) begin
        w_min[r] = WORD_MAX;
      end else if (sum_min[r] < SAT_LO) begin
        w_min[r] = WORD_MIN;
      end else begin
        w_min[r] = WORD_W'(sum_min[r]);
      end
      if (sum_max[r] > SAT_HI) begin
        w_max[r] = WORD_MAX;
      end else if (sum_max[r] < SAT_LO) begin
        w_max[r] = WORD_MIN;
      end else begin
        w_max[r] = WORD_W'(sum_max[r]);
      end

      base_lo[r]  = restart_i ? WORD_MAX : bound_lo_i[r];
      base_hi[r]  = restart_i ? WORD_MIN : bound_hi_i[r];
      new_lo_o[r] = (w_min[r] < base_lo[r]) ? w_min[r] : base_lo[r];
      new_hi_o[r] = (w_max[r] > base_hi[r]) ? w_max[r] : base_hi[r];
    end
  end

endmodule : tbba_merge

`default_nettype wire

### sv/tbba_checker.sv
// Port-level checker for the box bound accumulator, bound to the top level.
`default_nettype none

module tbba_checker import tbba_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  req_ready_i,
  input logic  rsp_valid_i,
  input logic  rsp_ready_i,
  input word_t min_x_i,
  input word_t min_y_i,
  input word_t min_z_i,
  input word_t max_x_i,
  input word_t max_y_i,
  input word_t max_z_i
);

  // A stalled response beat keeps its valid and its box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(min_x_i) && $stable(min_y_i)
      && $stable(min_z_i) && $stable(max_x_i) && $stable(max_y_i) && $stable(max_z_i))
    else $error("stalled response beat changed");

  // Every response box is ordered: its min is not above its max on any axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (min_x_i <= max_x_i) && (min_y_i <= max_y_i) && (min_z_i <= max_z_i))
    else $error("response box has min above max");

  // The box only moves together with a new response beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !($stable(min_x_i) && $stable(min_y_i) && $stable(min_z_i) && $stable(max_x_i)
      && $stable(max_y_i) && $stable(max_z_i)) |-> rsp_valid_i)
    else $error("box changed without a response beat");

  // With no response pending the pipeline drains, so requests are never held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request held while response side is free");

endmodule : tbba_checker

bind transformed_box_bound_accumulator tbba_checker u_tbba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .min_x_i     (rsp_o.world_min_x),
  .min_y_i     (rsp_o.world_min_y),
  .min_z_i     (rsp_o.world_min_z),
  .max_x_i     (rsp_o.world_max_x),
  .max_y_i     (rsp_o.world_max_y),
  .max_z_i     (rsp_o.world_max_z)
);

`default_nettype wire

### tb/transformed_box_bound_accumulator_tb.sv
// Self-checking testbench for the transformed box bound accumulator.
`default_nettype none

module transformed_box_bound_accumulator_tb import tbba_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam word_t ONE = word_t'(32'sh0001_0000);
  localparam int RANDOM_PER_PHASE = 150;
  localparam int STALL_CYCLES = 64;
  localparam int DRAIN_CYCLES = 8;

  // One request beat and one world box, at the block's widths.
  typedef struct {
    op_e   op;
    logic  restart;
    word_t coef[COLS];
    word_t lo[AXES];
    word_t hi[AXES];
  } beat_t;

  typedef struct {
    word_t low[AXES];
    word_t high[AXES];
  } box_t;

  // Keeps its own copy of the matrix and running box, and the boxes still owed.
  class box_scoreboard;
    word_t matrix[AXES*COLS];
    box_t  running;
    box_t  pending_boxes[$];
    int    errors;
    int    loads;
    int    expands;
    int    restarts;
    int    results;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      empty_running();
    endfunction

    function void empty_running();
      for (int a = 0; a < AXES; a++) begin
        running.low[a]  = WORD_MAX;
        running.high[a] = WORD_MIN;
      end
    endfunction

    // One matrix row applied to one corner: floored products, exact sum, then saturation.
    function word_t transform_axis(int row, word_t x, word_t y, word_t z);
      longint acc;
      acc = longint'(matrix[row*COLS+3]);
      acc += (longint'(matrix[row*COLS+0]) * longint'(x)) >>> FRAC;
      acc += (longint'(matrix[row*COLS+1]) * longint'(y)) >>> FRAC;
      acc += (longint'(matrix[row*COLS+2]) * longint'(z)) >>> FRAC;
      if (acc > 64'sd2147483647) return WORD_MAX;
      if (acc < -64'sd2147483648) return WORD_MIN;
      return word_t'(acc);
    endfunction

    function void note_request(beat_t b);
      word_t x, y, z, w;
      if (b.op != OP_EXPAND) begin
        for (int c = 0; c < COLS; c++) matrix[int'(b.op)*COLS+c] = b.coef[c];
        loads++;
        return;
      end
      expands++;
      if (b.restart) begin
        restarts++;
        empty_running();
      end
      // Fold all eight corners into the running box.
      for (int corner = 0; corner < 8; corner++) begin
        x = corner[0] ? b.hi[0] : b.lo[0];
        y = corner[1] ? b.hi[1] : b.lo[1];
        z = corner[2] ? b.hi[2] : b.lo[2];
        for (int a = 0; a < AXES; a++) begin
          w = transform_axis(a, x, y, z);
          if (w < running.low[a])  running.low[a]  = w;
          if (w > running.high[a]) running.high[a] = w;
        end
      end
      pending_boxes.insert(pending_boxes.size(), running);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_response(box_t got);
      box_t exp_box;
      string axis;
      results++;
      if (pending_boxes.size() == 0) begin
        flag("response beat with no expand outstanding");
        return;
      end
      exp_box = pending_boxes.pop_front();
      for (int a = 0; a < AXES; a++) begin
        axis = (a == 0) ? "x" : (a == 1) ? "y" : "z";
        if (got.low[a] !== exp_box.low[a])
          flag($sformatf("world_min_%s expected %h got %h", axis, exp_box.low[a], got.low[a]));
        if (got.high[a] !== exp_box.high[a])
          flag($sformatf("world_max_%s expected %h got %h", axis, exp_box.high[a],
                         got.high[a]));
      end
    endfunction

    function int outstanding();
      return pending_boxes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic hold_on;
  int   src_idle_pct;
  int   snk_idle_pct;
  box_scoreboard sb;

  tbba_req_if req ();
  tbba_rsp_if rsp ();

  transformed_box_bound_accumulator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Response side: check each accepted beat, then pick the next ready value.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        box_t got;
        got.low[0]  = rsp.world_min_x;
        got.low[1]  = rsp.world_min_y;
        got.low[2]  = rsp.world_min_z;
        got.high[0] = rsp.world_max_x;
        got.high[1] = rsp.world_max_y;
        got.high[2] = rsp.world_max_z;
        sb.check_response(got);
      end
      if (hold_on) begin
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Random coordinate: mostly moderate values, some full-range words and extremes.
  function automatic word_t pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 60) return word_t'(int'($urandom_range(33554431)) - 16777216);
    if (r < 85) return word_t'($urandom);
    case ($urandom_range(4))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return word_t'(-1);
      default: return word_t'(1);
    endcase
  endfunction

  // Random coefficient: mostly within a few units, some full-range words and extremes.
  function automatic word_t pick_coef();
    int r;
    r = $urandom_range(99);
    if (r < 60) return word_t'(int'($urandom_range(524287)) - 262144);
    if (r < 80) return word_t'($urandom);
    case ($urandom_range(5))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return ONE;
      4: return -ONE;
      default: return word_t'(-1);
    endcase
  endfunction

  // A row load; restart and the box fields carry noise that the block must ignore.
  function automatic beat_t mk_load(op_e op, word_t cx, word_t cy, word_t cz, word_t co);
    beat_t b;
    b.op = op;
    b.restart = 1'($urandom_range(1));
    b.coef[0] = cx;
    b.coef[1] = cy;
    b.coef[2] = cz;
    b.coef[3] = co;
    for (int a = 0; a < AXES; a++) begin
      b.lo[a] = word_t'($urandom);
      b.hi[a] = word_t'($urandom);
    end
    return b;
  endfunction

  function automatic beat_t mk_expand(logic restart, word_t lx, word_t ly, word_t lz,
                                      word_t hx, word_t hy, word_t hz);
    beat_t b;
    b.op = OP_EXPAND;
    b.restart = restart;
    for (int c = 0; c < COLS; c++) b.coef[c] = word_t'($urandom);
    b.lo[0] = lx;
    b.lo[1] = ly;
    b.lo[2] = lz;
    b.hi[0] = hx;
    b.hi[1] = hy;
    b.hi[2] = hz;
    return b;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    word_t t;
    if ($urandom_range(99) < 12) begin
      return mk_load(op_e'($urandom_range(2)), pick_coef(), pick_coef(), pick_coef(),
                     pick_coef());
    end
    b = mk_expand($urandom_range(99) < 20, pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_coord());
    // Most boxes are made well formed; the rest are left as drawn and may be inverted.
    if ($urandom_range(99) < 85) begin
      for (int a = 0; a < AXES; a++) begin
        if (b.lo[a] > b.hi[a]) begin
          t = b.lo[a];
          b.lo[a] = b.hi[a];
          b.hi[a] = t;
        end
      end
    end
    return b;
  endfunction

  // Offer one beat, with random gaps before it, and hold it until it is taken.
  task automatic push_beat(beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.operation   <= b.op;
    req.restart     <= b.restart;
    req.coef_x      <= b.coef[0];
    req.coef_y      <= b.coef[1];
    req.coef_z      <= b.coef[2];
    req.coef_offset <= b.coef[3];
    req.local_min_x <= b.lo[0];
    req.local_min_y <= b.lo[1];
    req.local_min_z <= b.lo[2];
    req.local_max_x <= b.hi[0];
    req.local_max_y <= b.hi[1];
    req.local_max_z <= b.hi[2];
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(b);
  endtask

  // Stop offering and wait for every owed response.
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Main sequence.
  initial begin
    sb = new();
    hold_on = 1'b0;
    src_idle_pct = 33;
    snk_idle_pct = 79;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.operation = OP_ROW_X;
    req.restart = 1'b0;
    req.coef_x = '0;
    req.coef_y = '0;
    req.coef_z = '0;
    req.coef_offset = '0;
    req.local_min_x = '0;
    req.local_min_y = '0;
    req.local_min_z = '0;
    req.local_max_x = '0;
    req.local_max_y = '0;
    req.local_max_z = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix, then growth from the empty box, containment and restart.
    push_beat(mk_load(OP_ROW_X, ONE, '0, '0, '0));
    push_beat(mk_load(OP_ROW_Y, '0, ONE, '0, '0));
    push_beat(mk_load(OP_ROW_Z, '0, '0, ONE, '0));
    push_beat(mk_expand(1'b0, -ONE, -2*ONE, -3*ONE, ONE, 2*ONE, 3*ONE));
    push_beat(mk_expand(1'b0, '0, '0, '0, ONE/2, ONE/2, ONE/2));
    push_beat(mk_expand(1'b0, 4*ONE, '0, '0, 9*ONE, ONE, ONE));
    push_beat(mk_expand(1'b1, 5*ONE, 5*ONE, 5*ONE, 6*ONE, 6*ONE, 6*ONE));
    // Inverted local box.
    push_beat(mk_expand(1'b0, 3*ONE, 3*ONE, 3*ONE, -3*ONE, -3*ONE, -3*ONE));
    push_beat(mk_expand(1'b1, WORD_MIN, WORD_MIN, WORD_MIN,
                        WORD_MAX, WORD_MAX, WORD_MAX));
    // Negative fractional coefficients round toward minus infinity.
    push_beat(mk_load(OP_ROW_X, word_t'(32'shFFFF_8000), word_t'(32'sh0000_5555),
                      '0, word_t'(7)));
    push_beat(mk_expand(1'b1, word_t'(-1), word_t'(-1), word_t'(-1),
                        word_t'(1), word_t'(1), word_t'(1)));
    // Extreme coefficients drive the sums into saturation both ways.
    push_beat(mk_load(OP_ROW_X, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    push_beat(mk_load(OP_ROW_Y, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    push_beat(mk_load(OP_ROW_Z, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
    push_beat(mk_expand(1'b1, WORD_MIN, WORD_MIN, WORD_MIN,
                        WORD_MAX, WORD_MAX, WORD_MAX));
    push_beat(mk_expand(1'b0, '0, '0, '0, '0, '0, '0));
    // Translation only, with extreme offsets.
    push_beat(mk_load(OP_ROW_X, '0, '0, '0, WORD_MIN));
    push_beat(mk_load(OP_ROW_Y, '0, '0, '0, WORD_MAX));
    push_beat(mk_load(OP_ROW_Z, '0, '0, '0, '0));
    push_beat(mk_expand(1'b1, '0, '0, '0, '0, '0, '0));
    push_beat(mk_expand(1'b0, WORD_MAX, WORD_MAX, WORD_MAX,
                        WORD_MIN, WORD_MIN, WORD_MIN));
    // A moderate matrix to start the random part from.
    push_beat(mk_load(OP_ROW_X, ONE, ONE/2, -ONE/4, 10*ONE));
    push_beat(mk_load(OP_ROW_Y, -ONE/2, ONE, ONE/8, -3*ONE));
    push_beat(mk_load(OP_ROW_Z, ONE/4, -ONE, 2*ONE, ONE));

    // Busy sender against a slow receiver.
    repeat (RANDOM_PER_PHASE) push_beat(random_beat());
    wait_drained();

    // Slow sender against a mostly ready receiver.
    src_idle_pct = 79;
    snk_idle_pct = 33;
    repeat (RANDOM_PER_PHASE) push_beat(random_beat());

    // Full rate; the receiver stalls for a long stretch so the input backs up.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    repeat (RANDOM_PER_PHASE) push_beat(random_beat());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d row loads and %0d expands (%0d with restart), %0d responses checked,",
             sb.loads, sb.expands, sb.restarts, sb.results);
    $display("under three pacing phases and one long response stall; %0d mismatches.",
             sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : transformed_box_bound_accumulator_tb

`default_nettype wire
